// ----- hdl/sldf_pkg.sv -----
// Shared types and constants for the sensor link reply deframer.
// No dependencies; imported by every module of the block.
package sldf_pkg;

   // Counted width of the sample channel mask
   localparam int CHANNELS = 8;
   localparam int CNT_W    = $clog2(CHANNELS + 1);

   // Message kinds as carried on the result channel
   typedef enum logic [3:0] {
      K_SHORTPING = 4'd0,
      K_READVALUE = 4'd1,
      K_WRITEACK  = 4'd2,
      K_DATAPAGE  = 4'd3,
      K_ERASE     = 4'd4,
      K_TRIGLOG   = 4'd5,
      K_FAILURE   = 4'd6,
      K_STOP      = 4'd7,
      K_BSACK     = 4'd8,
      K_LONGPING  = 4'd9,
      K_SAMPLE    = 4'd10,
      K_DISCOVERY = 4'd11
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_UNKNOWN   = 2'd1,
      ERR_STREAMING = 2'd2,
      ERR_TIMEOUT   = 2'd3
   } err_type;

   // Input operation codes
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

   // Lead bytes
   localparam logic [7:0] LEAD_SHORTPING = 8'h02;
   localparam logic [7:0] LEAD_READVALUE = 8'h03;
   localparam logic [7:0] LEAD_WRITEACK  = 8'h04;
   localparam logic [7:0] LEAD_DATAPAGE  = 8'h05;
   localparam logic [7:0] LEAD_ERASE     = 8'h06;
   localparam logic [7:0] LEAD_TRIGLOG   = 8'h0C;
   localparam logic [7:0] LEAD_FAILURE   = 8'h21;
   localparam logic [7:0] LEAD_STOP      = 8'h90;
   localparam logic [7:0] LEAD_MULTI     = 8'hAA;
   localparam logic [7:0] LEAD_STREAM    = 8'hFF;

   // Subheader bytes
   localparam logic [7:0] SUB_07         = 8'h07;
   localparam logic [7:0] SUB_01         = 8'h01;
   localparam logic [7:0] SUB_LONGPING   = 8'h02;
   localparam logic [7:0] SUB_SAMPLE     = 8'h04;
   localparam logic [7:0] SUB_STREAM     = 8'h05;
   localparam logic [7:0] SUB_DISCOVERY  = 8'h07;
   localparam int         SUB_DISC_BIT   = 3;

   // Payload lengths
   localparam logic [8:0] LEN_READVALUE  = 9'd4;
   localparam logic [8:0] LEN_DATAPAGE   = 9'd266;
   localparam logic [8:0] LEN_LONGPING   = 9'd9;
   localparam logic [8:0] LEN_SAMPLE_HDR = 9'd9;
   localparam logic [8:0] LEN_SAMPLE_TRL = 9'd4;
   localparam logic [8:0] LEN_DISCOVERY  = 9'd10;
   localparam logic [8:0] MASK_INDEX     = 9'd4;
   localparam logic [15:0] SUM_SEED      = 16'h0007 + 16'h0004;

   // Configuration register indexes
   localparam logic REG_EXPECT_MULTIPLE = 1'b0;

   // One input beat
   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } beat_type;

   // One result beat
   typedef struct packed {
      kind_type   msg_kind;
      logic       has_payload;
      logic [7:0] payload_byte;
      logic [8:0] byte_index;
      logic       last;
      logic       sum_ok;
      err_type    error_code;
   } result_type;

endpackage

// ----- hdl/sldf_in_stage.sv -----
// Input register of the deframer: holds one received beat for the framer.
// Depends on sldf_pkg.
module sldf_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sldf_pkg::beat_type req_beat,
   input  logic               room,
   output logic               beat_valid,
   output sldf_pkg::beat_type beat
);
   import sldf_pkg::*;

   logic     valid_ff, valid_in;
   beat_type beat_ff;

   // Take a new beat when empty or when the held one moves on
   assign req_ready = !valid_ff || room;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (room) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         beat_ff <= req_beat;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

// ----- hdl/sldf_framer.sv -----
// Framing state machine: one beat a cycle while step is high, zero or one result per beat.
// Depends on sldf_pkg.
module sldf_framer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  sldf_pkg::beat_type   beat,
   input  logic                 expect_multiple,
   output logic                 res_valid,
   output sldf_pkg::result_type res
);
   import sldf_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PAYLOAD,
      PH_SUB1,
      PH_SUB2
   } phase_type;

   phase_type  phase_ff, phase_in;
   kind_type   kind_ff, kind_in;
   logic [8:0] count_ff, count_in;
   logic [8:0] exp_ff, exp_in;
   logic [7:0] sub_ff, sub_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0] sumhi_ff, sumhi_in;

   logic       timeout;
   logic [7:0] b;
   logic [CNT_W-1:0] ones;
   logic [8:0] exp_eff;
   logic [9:0] idx_p1, idx_p2, idx_p4;
   logic       is_last;

   assign timeout = (beat.operation == OP_TIMEOUT);
   assign b       = beat.rx_byte;

   // Set channels in the sample mask
   always_comb begin
      ones = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         ones = ones + CNT_W'(b[i]);
      end
   end

   // Length as known after this byte: the mask byte fixes a sample's length
   always_comb begin
      exp_eff = exp_ff;
      if (kind_ff == K_SAMPLE && count_ff == MASK_INDEX) begin
         exp_eff = LEN_SAMPLE_HDR + LEN_SAMPLE_TRL + 9'({ones, 1'b0});
      end
   end

   assign idx_p1  = {1'b0, count_ff} + 10'd1;
   assign idx_p2  = {1'b0, count_ff} + 10'd2;
   assign idx_p4  = {1'b0, count_ff} + 10'd4;
   assign is_last = (idx_p1 >= {1'b0, exp_eff});

   // Next state and result
   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      count_in  = count_ff;
      exp_in    = exp_ff;
      sub_in    = sub_ff;
      sum_in    = sum_ff;
      sumhi_in  = sumhi_ff;
      res_valid = 1'b0;
      res       = '{msg_kind: K_SHORTPING, has_payload: 1'b0, payload_byte: 8'd0,
                    byte_index: 9'd0, last: 1'b1, sum_ok: 1'b0,
                    error_code: ERR_NONE};

      unique case (phase_ff)
         PH_IDLE: begin
            if (!timeout) begin
               res_valid = 1'b1;
               case (b)
                  LEAD_SHORTPING: res.msg_kind = K_SHORTPING;
                  LEAD_READVALUE: begin
                     res_valid = 1'b0;
                     phase_in  = PH_PAYLOAD;
                     kind_in   = K_READVALUE;
                     exp_in    = LEN_READVALUE;
                  end
                  LEAD_WRITEACK:  res.msg_kind = K_WRITEACK;
                  LEAD_DATAPAGE: begin
                     res_valid = 1'b0;
                     phase_in  = PH_PAYLOAD;
                     kind_in   = K_DATAPAGE;
                     exp_in    = LEN_DATAPAGE;
                  end
                  LEAD_ERASE:     res.msg_kind = K_ERASE;
                  LEAD_TRIGLOG:   res.msg_kind = K_TRIGLOG;
                  LEAD_FAILURE:   res.msg_kind = K_FAILURE;
                  LEAD_STOP:      res.msg_kind = K_STOP;
                  LEAD_MULTI: begin
                     if (expect_multiple) begin
                        res_valid = 1'b0;
                        phase_in  = PH_SUB1;
                     end else begin
                        res.msg_kind = K_BSACK;
                     end
                  end
                  LEAD_STREAM:    res.error_code = ERR_STREAMING;
                  default:        res.error_code = ERR_UNKNOWN;
               endcase
            end
         end

         PH_SUB1: begin
            if (timeout) begin
               res_valid    = 1'b1;
               res.msg_kind = K_BSACK;
               phase_in     = PH_IDLE;
            end else begin
               sub_in   = b;
               phase_in = PH_SUB2;
            end
         end

         PH_SUB2: begin
            phase_in = PH_IDLE;
            if (timeout) begin
               res_valid    = 1'b1;
               res.msg_kind = K_BSACK;
            end else if (sub_ff == SUB_07 && b == SUB_LONGPING) begin
               phase_in = PH_PAYLOAD;
               kind_in  = K_LONGPING;
               exp_in   = LEN_LONGPING;
            end else if (sub_ff == SUB_07 && b == SUB_SAMPLE) begin
               phase_in = PH_PAYLOAD;
               kind_in  = K_SAMPLE;
               exp_in   = LEN_SAMPLE_HDR;
            end else if (sub_ff == SUB_01 && b == SUB_STREAM) begin
               res_valid      = 1'b1;
               res.error_code = ERR_STREAMING;
            end else if (sub_ff[SUB_DISC_BIT] && b == SUB_DISCOVERY) begin
               phase_in = PH_PAYLOAD;
               kind_in  = K_DISCOVERY;
               exp_in   = LEN_DISCOVERY;
            end else begin
               res_valid    = 1'b1;
               res.msg_kind = K_BSACK;
            end
         end

         PH_PAYLOAD: begin
            res_valid    = 1'b1;
            res.msg_kind = kind_ff;
            if (timeout) begin
               res.error_code = ERR_TIMEOUT;
               phase_in       = PH_IDLE;
            end else begin
               // Sample packets track length and checksum as bytes pass
               if (kind_ff == K_SAMPLE) begin
                  exp_in = exp_eff;
                  if (idx_p4 < {1'b0, exp_eff}) begin
                     sum_in = sum_ff + {8'd0, b};
                  end
                  if (idx_p2 == {1'b0, exp_eff}) begin
                     sumhi_in = b;
                  end
               end
               res.has_payload  = 1'b1;
               res.payload_byte = b;
               res.byte_index   = count_ff;
               res.last         = is_last;
               res.sum_ok       = is_last && (kind_ff == K_SAMPLE) &&
                                  ({sumhi_in, b} == sum_in);
               count_in         = idx_p1[8:0];
               if (is_last) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      // Entering a payload resets the per-message counters
      if (phase_ff != PH_PAYLOAD && phase_in == PH_PAYLOAD) begin
         count_in = 9'd0;
         sum_in   = SUM_SEED;
         sumhi_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         kind_ff  <= K_SHORTPING;
         count_ff <= 9'd0;
         exp_ff   <= 9'd0;
         sub_ff   <= 8'd0;
         sum_ff   <= 16'd0;
         sumhi_ff <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         count_ff <= count_in;
         exp_ff   <= exp_in;
         sub_ff   <= sub_in;
         sum_ff   <= sum_in;
         sumhi_ff <= sumhi_in;
      end
   end

   // A message's final result always leaves the framer idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && res.last |=> phase_ff == PH_IDLE)
      else $error("framer not idle after final result");

   // Markers are always final and errors only come on markers
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      res_valid && (!res.has_payload || res.error_code != ERR_NONE) |->
      res.last && !res.has_payload)
      else $error("marker result malformed");

   // Checksum verdict only on the final byte of a sample packet
   a_sum_ok: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.sum_ok |-> res.last && res.msg_kind == K_SAMPLE &&
      res.has_payload)
      else $error("sum_ok outside sample packet end");

   // Payload indices stay below the message length
   a_index: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_PAYLOAD && !timeout |-> count_ff < exp_eff)
      else $error("payload index beyond length");

endmodule

// ----- hdl/sldf_out_stage.sv -----
// Result register: holds one result beat until the receiver takes it.
// Depends on sldf_pkg.
module sldf_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 res_valid,
   input  sldf_pkg::result_type res,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sldf_pkg::result_type rsp
);
   import sldf_pkg::*;

   logic       valid_ff;
   result_type res_ff;

   // Free when empty or when the held beat is being taken
   assign room = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (room) begin
         valid_ff <= load && res_valid;
      end
      if (room && load && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = res_ff;

endmodule

// ----- hdl/sensor_link_reply_deframer_core.sv -----
// Sensor link reply deframer, top level.
// Depends on sldf_pkg, sldf_in_stage, sldf_framer and sldf_out_stage.
//
// Use:
//   req_* carries one received byte or one receive-timeout event per beat
//   (req_operation 0 byte, 1 timeout). rsp_* carries framed results: one
//   per payload byte, or one marker for a message without payload.
//   Each request beat gives zero or one result beat.
//   Both channels use valid/ready; a beat moves when both are high.
//   An APB-style register port holds expect_multiple (address 0, bit 0).
// Timing:
//   A request beat is held in the input register, framed combinationally from
//   there, and its result is loaded into the output register when the framer
//   steps; rsp_valid rises once the result is in the output register.
//   One beat per cycle is sustained while rsp_ready stays high; the framer
//   state update is combinational logic between the two registers.
// Reset clears the framer to idle, empties both registers and sets
//   expect_multiple to 1.
// When rsp_ready is low the output register holds its beat; the input
//   register still fills, and req_ready drops only once both are occupied.
module sensor_link_reply_deframer_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_rx_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_msg_kind,
   output logic        rsp_has_payload,
   output logic [7:0]  rsp_payload_byte,
   output logic [8:0]  rsp_byte_index,
   output logic        rsp_last,
   output logic        rsp_sum_ok,
   output logic [1:0]  rsp_error_code,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import sldf_pkg::*;

   beat_type   req_beat, beat;
   result_type res, rsp;
   logic       beat_valid, room, step, res_valid;
   logic       expect_multiple_ff;

   // Register port: one register, written in the access phase
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_multiple_ff <= 1'b1;
      end else if (psel && penable && pwrite && paddr[2] == REG_EXPECT_MULTIPLE) begin
         expect_multiple_ff <= pwdata[0];
      end
   end

   assign prdata = (paddr[2] == REG_EXPECT_MULTIPLE) ? {31'd0, expect_multiple_ff} : 32'd0;

   assign req_beat = '{operation: req_operation, rx_byte: req_rx_byte};

   sldf_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_beat   (req_beat),
      .room       (room),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   // Framer advances whenever a held beat can move on
   assign step = beat_valid && room;

   sldf_framer u_framer (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .beat            (beat),
      .expect_multiple (expect_multiple_ff),
      .res_valid       (res_valid),
      .res             (res)
   );

   sldf_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .res_valid (res_valid),
      .res       (res),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_msg_kind     = rsp.msg_kind;
   assign rsp_has_payload  = rsp.has_payload;
   assign rsp_payload_byte = rsp.payload_byte;
   assign rsp_byte_index   = rsp.byte_index;
   assign rsp_last         = rsp.last;
   assign rsp_sum_ok       = rsp.sum_ok;
   assign rsp_error_code   = rsp.error_code;

endmodule
